@@ src/aabb_pkg.sv @@
// Shared constants for the AABB sweep-and-prune broadphase: operation codes,
// fixed field widths and parameter defaults. No dependencies.
`timescale 1ns / 1ps

package aabb_pkg;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned SLOT_W = 3;

  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_SWEEP  = 2'd2;

  localparam int unsigned MAX_BOXES_DEF  = 8;
  localparam int unsigned COORD_BITS_DEF = 16;

  // Boxes are packed as six coordinates: min_x, max_x, min_y, max_y, min_z, max_z
  // from the low end up.
  localparam int unsigned BOX_COORDS = 6;

endpackage

@@ src/aabb_ovl.sv @@
// Three-axis inclusive interval overlap test between two packed boxes.
// Depends on aabb_pkg for the box packing.
`timescale 1ns / 1ps

module aabb_ovl #(
  parameter int unsigned COORD_BITS = aabb_pkg::COORD_BITS_DEF
) (
  input  logic [aabb_pkg::BOX_COORDS*COORD_BITS-1:0] box_a,
  input  logic [aabb_pkg::BOX_COORDS*COORD_BITS-1:0] box_b,
  output logic                                      hit
);

  logic [2:0] axis_hit;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      axis_hit[k] =
        ($signed(box_a[(2*k)*COORD_BITS +: COORD_BITS]) <=
         $signed(box_b[(2*k+1)*COORD_BITS +: COORD_BITS])) &&
        ($signed(box_b[(2*k)*COORD_BITS +: COORD_BITS]) <=
         $signed(box_a[(2*k+1)*COORD_BITS +: COORD_BITS]));
    end
  end

  assign hit = &axis_hit;

endmodule

@@ src/aabb_sweep_and_prune_broadphase.sv @@
// Top level of the AABB sweep-and-prune broadphase: box memory, valid bits,
// pair sweep sequencer and result holding. Depends on aabb_pkg and aabb_ovl.
`timescale 1ns / 1ps

// Channel   Direction  Handshake         Payload
// in_*      input      in_valid/in_stall opcode, slot, min/max per axis
// out_*     output     out_valid/out_stall found, first_slot, second_slot, last
//
// Write and remove return no result.
// A sweep walks every slot pair (MAX_BOXES*(MAX_BOXES-1)/2 pairs, 28 at eight
// slots) at one pair per cycle through the dual-read box memory; an output
// stall freezes the walk when a new hit must push out the held hit.
// Reset clears valid bits and control; box contents stay undefined until written.
// No new request is taken while a sweep is running.

module aabb_sweep_and_prune_broadphase #(
  parameter int unsigned MAX_BOXES  = aabb_pkg::MAX_BOXES_DEF,
  parameter int unsigned COORD_BITS = aabb_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [aabb_pkg::OP_W-1:0]         in_opcode,
  input  logic [aabb_pkg::SLOT_W-1:0]       in_slot,
  input  logic signed [COORD_BITS-1:0]      in_min_x,
  input  logic signed [COORD_BITS-1:0]      in_max_x,
  input  logic signed [COORD_BITS-1:0]      in_min_y,
  input  logic signed [COORD_BITS-1:0]      in_max_y,
  input  logic signed [COORD_BITS-1:0]      in_min_z,
  input  logic signed [COORD_BITS-1:0]      in_max_z,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_found,
  output logic [aabb_pkg::SLOT_W-1:0]       out_first_slot,
  output logic [aabb_pkg::SLOT_W-1:0]       out_second_slot,
  output logic                              out_last
);

  localparam int unsigned IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int unsigned BOX_W = aabb_pkg::BOX_COORDS * COORD_BITS;
  localparam int unsigned SW    = aabb_pkg::SLOT_W;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_BOXES - 1);
  localparam logic [IDX_W-1:0] IDX_PEN  = IDX_W'(MAX_BOXES - 2);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  // Box memory with two registered read ports.
  logic [BOX_W-1:0] box_mem [MAX_BOXES];
  logic [BOX_W-1:0] rd_a_r, rd_b_r;

  logic [1:0]           state_r, state_nxt;
  logic [MAX_BOXES-1:0] valid_r, valid_nxt;

  // Pair issue counters.
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic             iss_done_r, iss_done_nxt;

  // Compare stage: pair whose boxes sit in the read registers.
  logic             p_vld_r, p_vld_nxt;
  logic             p_ok_r, p_ok_nxt;
  logic             p_end_r, p_end_nxt;
  logic [IDX_W-1:0] p_i_r, p_i_nxt, p_j_r, p_j_nxt;

  // Pending hit: held back until we know whether it is the last one.
  logic             pend_vld_r, pend_vld_nxt;
  logic [IDX_W-1:0] pend_i_r, pend_i_nxt, pend_j_r, pend_j_nxt;

  // Output register.
  logic          out_vld_r, out_vld_nxt;
  logic          out_found_r, out_found_nxt;
  logic [SW-1:0] out_first_r, out_first_nxt, out_second_r, out_second_nxt;
  logic          out_last_r, out_last_nxt;

  logic             hit;
  logic             in_acc, out_free, adv, issue, last_pair, slot_ok, p_hit;
  logic [IDX_W-1:0] wa;

  aabb_ovl #(
    .COORD_BITS (COORD_BITS)
  ) u_ovl (
    .box_a (rd_a_r),
    .box_b (rd_b_r),
    .hit   (hit)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_vld_r || !out_stall;
  assign slot_ok   = (int'(in_slot) < int'(MAX_BOXES));
  assign wa        = IDX_W'(in_slot);
  assign p_hit     = p_vld_r && p_ok_r && hit;
  // Hold the compare stage when a second hit must push the pending one out while the output is still occupied.
  assign adv       = !(p_hit && pend_vld_r) || out_free;
  assign issue     = (state_r == ST_SWEEP) && !iss_done_r && adv;
  assign last_pair = (i_r == IDX_PEN) && (j_r == IDX_LAST);

  always_ff @(posedge clk) begin
    if (in_acc && (in_opcode == aabb_pkg::OP_WRITE) && slot_ok) begin
      box_mem[wa] <= {in_max_z, in_min_z, in_max_y, in_min_y, in_max_x, in_min_x};
    end
    if (issue) begin
      rd_a_r <= box_mem[i_r];
      rd_b_r <= box_mem[j_r];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    iss_done_nxt   = iss_done_r;
    p_vld_nxt      = p_vld_r;
    p_ok_nxt       = p_ok_r;
    p_end_nxt      = p_end_r;
    p_i_nxt        = p_i_r;
    p_j_nxt        = p_j_r;
    pend_vld_nxt   = pend_vld_r;
    pend_i_nxt     = pend_i_r;
    pend_j_nxt     = pend_j_r;
    out_vld_nxt    = out_vld_r;
    out_found_nxt  = out_found_r;
    out_first_nxt  = out_first_r;
    out_second_nxt = out_second_r;
    out_last_nxt   = out_last_r;

    // Drop the result once taken.
    if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end

    // Decode an accepted request.
    if (in_acc) begin
      unique case (in_opcode)
        aabb_pkg::OP_WRITE: begin
          if (slot_ok) valid_nxt[wa] = 1'b1;
        end
        aabb_pkg::OP_REMOVE: begin
          if (slot_ok) valid_nxt[wa] = 1'b0;
        end
        aabb_pkg::OP_SWEEP: begin
          state_nxt    = ST_SWEEP;
          i_nxt        = '0;
          j_nxt        = IDX_W'(1);
          iss_done_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end

    // Compare stage: a new hit pushes the held one out as a non-final result.
    if (adv && p_vld_r) begin
      if (p_hit) begin
        if (pend_vld_r) begin
          out_vld_nxt    = 1'b1;
          out_found_nxt  = 1'b1;
          out_first_nxt  = SW'(pend_i_r);
          out_second_nxt = SW'(pend_j_r);
          out_last_nxt   = 1'b0;
        end
        pend_vld_nxt = 1'b1;
        pend_i_nxt   = p_i_r;
        pend_j_nxt   = p_j_r;
      end
      if (p_end_r) state_nxt = ST_FLUSH;
    end

    // Issue stage: launch the next pair's memory reads.
    if (adv) begin
      p_vld_nxt = issue;
      if (issue) begin
        p_i_nxt   = i_r;
        p_j_nxt   = j_r;
        p_ok_nxt  = valid_r[i_r] && valid_r[j_r];
        p_end_nxt = last_pair;
        if (last_pair) begin
          iss_done_nxt = 1'b1;
        end else if (j_r == IDX_LAST) begin
          i_nxt = i_r + IDX_W'(1);
          j_nxt = i_r + IDX_W'(2);
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
    end

    // Close the sweep: emit the held hit as final, or the empty result.
    if ((state_r == ST_FLUSH) && out_free) begin
      out_vld_nxt    = 1'b1;
      out_found_nxt  = pend_vld_r;
      out_first_nxt  = pend_vld_r ? SW'(pend_i_r) : '0;
      out_second_nxt = pend_vld_r ? SW'(pend_j_r) : '0;
      out_last_nxt   = 1'b1;
      pend_vld_nxt   = 1'b0;
      state_nxt      = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      valid_r    <= '0;
      iss_done_r <= 1'b1;
      p_vld_r    <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      valid_r    <= valid_nxt;
      iss_done_r <= iss_done_nxt;
      p_vld_r    <= p_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    p_ok_r       <= p_ok_nxt;
    p_end_r      <= p_end_nxt;
    p_i_r        <= p_i_nxt;
    p_j_r        <= p_j_nxt;
    pend_i_r     <= pend_i_nxt;
    pend_j_r     <= pend_j_nxt;
    out_found_r  <= out_found_nxt;
    out_first_r  <= out_first_nxt;
    out_second_r <= out_second_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_vld_r;
  assign out_found       = out_found_r;
  assign out_first_slot  = out_first_r;
  assign out_second_slot = out_second_r;
  assign out_last        = out_last_r;

endmodule
